>>> rtl/core/etps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etps_pkg: shared constants and types for the exp Taylor partial sum block
// Holds the fixed-point constants, field widths and the command struct that
// the controller sends to the datapath.
// ----------------------------------------------------------------------------
package etps_pkg;

  localparam int MAX_TERMS_DEF = 128;

  localparam int X_W    = 32;
  localparam int TERM_W = 7;
  localparam int SUM_W  = 64;

  // The divider retires this many quotient bits per cycle.
  localparam int RADIX_BITS = 8;
  localparam int DIV_CYCLES = SUM_W / RADIX_BITS;

  localparam logic [SUM_W-1:0] ONE_Q40     = 64'h0000_0100_0000_0000;
  localparam logic [SUM_W-1:0] POS_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0] NEG_LIMIT   = 64'h8000_0000_0000_0000;
  localparam logic [SUM_W-1:0] ADD_ONE_MAX = POS_LIMIT - ONE_Q40;
  localparam logic [SUM_W-1:0] ROUND_Q28   = 64'h0000_0000_0800_0000;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic comb;
    logic div;
    logic rnd;
    logic upd;
    logic add_one;
    logic out_zero;
    logic out_sum;
  } etps_cmd_t;

endpackage

>>> rtl/core/etps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etps_ctrl: sequencer for the exp Taylor partial sum
// Walks the Horner phase from the highest term down, then the scaling phase
// by x/i, and steps the datapath through multiply, divide and update.
// ----------------------------------------------------------------------------
module etps_ctrl #(
  parameter int MAX_TERMS = etps_pkg::MAX_TERMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [etps_pkg::TERM_W-1:0]     first_term,
  input  logic [etps_pkg::TERM_W-1:0]     last_term,
  output logic                            busy,
  output etps_pkg::etps_cmd_t             cmd,
  output logic [$clog2(MAX_TERMS)-1:0]    divisor
);
  import etps_pkg::*;

  localparam int DW         = $clog2(MAX_TERMS);
  localparam int CW         = $clog2(MAX_TERMS + 1);
  localparam int TERM_LIMIT = MAX_TERMS - 1;
  localparam int DCW        = $clog2(DIV_CYCLES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEL    = 3'd1;
  localparam logic [2:0] S_MUL_LO = 3'd2;
  localparam logic [2:0] S_MUL_HI = 3'd3;
  localparam logic [2:0] S_COMB   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_RND    = 3'd6;
  localparam logic [2:0] S_UPD    = 3'd7;

  logic [2:0]     state, state_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [CW-1:0]  first_c;
  logic [CW-1:0]  first_in, last_in;
  logic           scale, scale_next;
  logic [DCW-1:0] div_cnt, div_cnt_next;

  // Term indexes beyond the table range are clamped to the last index.
  assign first_in = (int'(first_term) > TERM_LIMIT) ? CW'(TERM_LIMIT) : CW'(first_term);
  assign last_in  = (int'(last_term) > TERM_LIMIT) ? CW'(TERM_LIMIT) : CW'(last_term);

  assign busy    = (state != S_IDLE);
  assign divisor = cnt[DW-1:0];

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    scale_next   = scale;
    div_cnt_next = div_cnt;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_in < first_in) begin
            cmd.out_zero = 1'b1;
          end else begin
            state_next = S_SEL;
            cnt_next   = last_in;
            scale_next = 1'b0;
          end
        end
      end
      S_SEL: begin
        if (!scale) begin
          if (cnt > first_c) begin
            state_next = S_MUL_LO;
          end else begin
            scale_next = 1'b1;
            cnt_next   = CW'(1);
          end
        end else begin
          if (cnt <= first_c) begin
            state_next = S_MUL_LO;
          end else begin
            cmd.out_sum = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_COMB;
      end
      S_COMB: begin
        cmd.comb     = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div      = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DCW'(DIV_CYCLES - 1)) begin
          state_next = S_RND;
        end
      end
      S_RND: begin
        cmd.rnd    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd     = 1'b1;
        cmd.add_one = !scale;
        cnt_next    = scale ? (cnt + 1'b1) : (cnt - 1'b1);
        state_next  = S_SEL;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      scale   <= 1'b0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      scale   <= scale_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      first_c <= first_in;
    end
  end

endmodule

>>> rtl/core/etps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etps_dp: datapath for the exp Taylor partial sum
// One shared 32x32 multiplier, a radix-256 restoring divider by the term
// index, rounding, saturation and the add of 1.0 for the Horner step.
// ----------------------------------------------------------------------------
module etps_dp #(
  parameter int MAX_TERMS = etps_pkg::MAX_TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  etps_pkg::etps_cmd_t                 cmd,
  input  logic [$clog2(MAX_TERMS)-1:0]        divisor,
  input  logic signed [etps_pkg::X_W-1:0]     x_value,
  output logic                                done,
  output logic signed [etps_pkg::SUM_W-1:0]   partial_sum,
  output logic                                overflow
);
  import etps_pkg::*;

  localparam int DW  = $clog2(MAX_TERMS);
  localparam int PW  = 2 * X_W;
  localparam int FW  = PW + 4;
  localparam int RSH = 28;

  logic [X_W-1:0]   xmag;
  logic             xneg;
  logic [SUM_W-1:0] r;
  logic [SUM_W-1:0] rmag;
  logic             rneg;
  logic             sat;
  logic [PW-1:0]    prod_lo, prod_hi;
  logic [SUM_W-1:0] dvd;
  logic [DW-1:0]    rem;
  logic             neg;
  logic [SUM_W-1:0] tmag;

  logic [X_W-1:0]   mul_a;
  logic [PW-1:0]    mul_p;
  logic [PW-1:0]    lo_rounded;
  logic [FW-1:0]    full;
  logic             full_ovf;
  logic [DW:0]      trial;
  logic [DW-1:0]    rem_w;
  logic [SUM_W-1:0] dvd_w;
  logic             rnd_up;
  logic [SUM_W:0]   t_round;
  logic [SUM_W-1:0] limit;

  assign mul_a = cmd.mul_hi ? rmag[SUM_W-1:X_W] : rmag[X_W-1:0];
  assign mul_p = mul_a * xmag;

  // Product of magnitudes is hi * 2^32 + lo; after the rounding shift by 28
  // the high half lands four bits up.
  assign lo_rounded = prod_lo + ROUND_Q28;
  assign full = {prod_hi, 4'b0000} + {{(FW-PW+RSH){1'b0}}, lo_rounded[PW-1:RSH]};
  assign full_ovf = |full[FW-1:SUM_W];

  always_comb begin
    rem_w = rem;
    dvd_w = dvd;
    trial = '0;
    for (int j = 0; j < RADIX_BITS; j++) begin
      trial = {rem_w, dvd_w[SUM_W-1]};
      dvd_w = {dvd_w[SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_w    = DW'(trial - {1'b0, divisor});
        dvd_w[0] = 1'b1;
      end else begin
        rem_w = trial[DW-1:0];
      end
    end
  end

  // Round half away from zero: bump when twice the remainder reaches the divisor.
  assign rnd_up  = ({rem, 1'b0} >= {1'b0, divisor});
  assign t_round = {1'b0, dvd} + {{SUM_W{1'b0}}, rnd_up};
  assign limit   = neg ? NEG_LIMIT : POS_LIMIT;

  always_ff @(posedge clk) begin
    rmag <= r[SUM_W-1] ? (~r + 1'b1) : r;
    rneg <= r[SUM_W-1];
    if (cmd.load) begin
      xmag <= x_value[X_W-1] ? (~$unsigned(x_value) + 1'b1) : $unsigned(x_value);
      xneg <= x_value[X_W-1];
      r    <= ONE_Q40;
      sat  <= 1'b0;
    end
    if (cmd.mul_lo) begin
      prod_lo <= mul_p;
    end
    if (cmd.mul_hi) begin
      prod_hi <= mul_p;
    end
    if (cmd.comb) begin
      dvd <= full_ovf ? '1 : full[SUM_W-1:0];
      rem <= '0;
      neg <= rneg ^ xneg;
      if (full_ovf) begin
        sat <= 1'b1;
      end
    end
    if (cmd.div) begin
      dvd <= dvd_w;
      rem <= rem_w;
    end
    if (cmd.rnd) begin
      if (t_round > {1'b0, limit}) begin
        tmag <= limit;
        sat  <= 1'b1;
      end else begin
        tmag <= t_round[SUM_W-1:0];
      end
    end
    if (cmd.upd) begin
      if (cmd.add_one) begin
        // Adding 1.0 to a non-positive value can never overflow.
        if (neg) begin
          r <= ONE_Q40 - tmag;
        end else if (tmag > ADD_ONE_MAX) begin
          r   <= POS_LIMIT;
          sat <= 1'b1;
        end else begin
          r <= tmag + ONE_Q40;
        end
      end else begin
        r <= neg ? (~tmag + 1'b1) : tmag;
      end
    end
    if (cmd.out_zero) begin
      partial_sum <= '0;
      overflow    <= 1'b0;
    end else if (cmd.out_sum) begin
      partial_sum <= $signed(r);
      overflow    <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_zero | cmd.out_sum;
    end
  end

endmodule

>>> rtl/core/exp_taylor_partial_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_taylor_partial_sum: fixed-point partial sum of the exponential series
// A request gives x (signed Q4.28) and a term range; the block returns the
// sum of x^k/k! over that range in signed Q24.40 with a saturation flag.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// x_value, first_term and last_term are sampled at that edge only.
// The result shows on partial_sum and overflow for one cycle with done high.
// The receiver cannot hold a result off; it must take it in that cycle.
// Term indexes above MAX_TERMS-1 are clamped to MAX_TERMS-1.
// An empty range (last below first) gives done in the cycle after the request.
// Otherwise each term takes two passes of the shared 32x32 multiplier, a
// combine step, the radix-256 divider, rounding, update and step selection.
// Busy is low again in the cycle done is high, so the next request can be
// taken then.
// Synchronous reset returns the sequencer to idle and clears done.
// ----------------------------------------------------------------------------
module exp_taylor_partial_sum #(
  parameter int MAX_TERMS = etps_pkg::MAX_TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [etps_pkg::X_W-1:0]     x_value,
  input  logic [etps_pkg::TERM_W-1:0]         first_term,
  input  logic [etps_pkg::TERM_W-1:0]         last_term,
  output logic                                done,
  output logic signed [etps_pkg::SUM_W-1:0]   partial_sum,
  output logic                                overflow
);
  import etps_pkg::*;

  etps_cmd_t                     cmd;
  logic [$clog2(MAX_TERMS)-1:0]  divisor;

  etps_ctrl #(
    .MAX_TERMS(MAX_TERMS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .first_term (first_term),
    .last_term  (last_term),
    .busy       (busy),
    .cmd        (cmd),
    .divisor    (divisor)
  );

  etps_dp #(
    .MAX_TERMS(MAX_TERMS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .divisor     (divisor),
    .x_value     (x_value),
    .done        (done),
    .partial_sum (partial_sum),
    .overflow    (overflow)
  );

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the sequencer is busy");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div |-> (divisor != '0))
    else $error("divider running with a zero term index");

  a_empty_range: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (last_term < first_term) && (int'(last_term) < MAX_TERMS - 1))
    |=> (done && (partial_sum == '0) && !overflow))
    else $error("empty range did not return zero in the next cycle");
`endif

endmodule
